>>> rtl/core/rmad_pkg.sv
// Shared types and constants for the running moving average deviation block.
package rmad_pkg;

  localparam int unsigned WIN_W     = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned SCALE_W   = 7;
  localparam int unsigned Q_FRAC    = 16;

  localparam logic [WIN_W-1:0]   WIN_RESET   = 12'd14;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 13'h1FFF;
  localparam logic [SCALE_W-1:0] PERCENT     = 7'd100;
  localparam logic [OUT_W-1:0]   DEV_MAX_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0]   DEV_MIN_NEG = 32'h8000_0000;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/running_moving_average_deviation.sv
// Wilder running moving average with percentage deviation of the previous sample.
//
// Input words arrive on in_*: tdata carries the sample (value times 256), tuser
// marks the first sample of a series. Result words leave on out_*: tdata carries
// the average (low 32 bits) and the signed Q16.16 deviation (high 32 bits),
// tuser flags a zero average. The user must write the smoothing period through
// cfg_wr_en and cfg_wr_data only while no word is in flight; the block itself
// does not enforce this. A word that only builds up the seed sum is taken
// without leaving the idle state. A word that produces a result needs a multiply
// step and passes through the shared radix-2 divider, once for the average and,
// unless the average is zero, once more for the deviation, with start, done and
// sequencing steps around them; the next word can be taken once its result has
// been handed to the output register. The seeding word skips the multiply.
// The divider is the only long path and in_tready stays low while it runs.
// The result sits in an output register; if the receiver stalls, the next
// input word is still accepted and computed, and only its hand-off waits.
// Reset clears the series state and sets the period to 14.
module running_moving_average_deviation
  import rmad_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH          = 32,
  parameter int unsigned AVERAGE_FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,
  // first_of_series
  input  logic                                  in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // average [31:0], deviation_percent [63:32]
  output logic [2*OUT_W-1:0]                    out_tdata,
  // zero_average
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_wr_en,
  input  logic [WIN_W-1:0]                      cfg_wr_data
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned FB    = AVERAGE_FRACTION_BITS;
  localparam int unsigned AVG_W = SW + FB;
  localparam int unsigned SUM_W = SW + WIN_W;
  localparam int unsigned NUM_W = AVG_W + SCALE_W + Q_FRAC;
  localparam int unsigned DEN_W = (AVG_W > WIN_W) ? AVG_W : WIN_W;
  localparam int unsigned QE_W  = (NUM_W > OUT_W + 1) ? NUM_W : OUT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DEV  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [WIN_W-1:0]   wl_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   seed_r, seed_nxt;
  logic [AVG_W-1:0]   pa_r, pa_nxt;
  logic [SW-1:0]      ps_r, ps_nxt;
  logic [SW-1:0]      x_r, x_nxt;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic               start_r, start_nxt;
  logic [AVG_W-1:0]   avg_r, avg_nxt;
  logic               neg_r, neg_nxt;
  logic [OUT_W-1:0]   dev_r, dev_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_avg_r, out_avg_nxt;
  logic [OUT_W-1:0]   out_dev_r, out_dev_nxt;
  logic               out_zero_r, out_zero_nxt;

  logic [WIN_W-1:0]     n;
  logic [COUNT_W-1:0]   idx_in;
  logic [SW-1:0]        x_in;
  logic [SUM_W-1:0]     seed_add;
  logic [AVG_W+WIN_W-1:0] prod;
  logic [AVG_W-1:0]     x_shift;
  logic [AVG_W-1:0]     p_shift;
  logic                 p_below;
  logic [AVG_W-1:0]     mag;
  logic [NUM_W-1:0]     dev_num;
  logic [QE_W-1:0]      q_ext;
  logic [OUT_W-1:0]     dev_sat;
  logic [AVG_W+OUT_W-1:0] avg_wide;
  logic [NUM_W-1:0]     div_q;
  div_stat_t            div_stat;

  rmad_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (num_r),
    .divisor  (den_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  assign n        = (wl_r == '0) ? WIN_W'(1) : wl_r;
  assign x_in     = in_tdata[SW-1:0];
  assign idx_in   = in_tuser ? '0 : count_r;
  assign seed_add = seed_r + SUM_W'(x_in);
  assign prod     = pa_r * (n - WIN_W'(1));
  assign x_shift  = AVG_W'(x_r) << FB;
  assign p_shift  = AVG_W'(ps_r) << FB;
  assign p_below  = p_shift < avg_r;
  assign mag      = p_below ? (avg_r - p_shift) : (p_shift - avg_r);
  assign dev_num  = (NUM_W'(mag) * NUM_W'(PERCENT)) << Q_FRAC;
  assign q_ext    = QE_W'(div_q);
  assign avg_wide = (AVG_W + OUT_W)'(avg_r) >> FB;

  // Deviation is truncated toward zero, then clamped to the signed 32-bit range.
  always_comb begin
    if (!neg_r) begin
      dev_sat = (q_ext > QE_W'(DEV_MAX_POS)) ? DEV_MAX_POS : q_ext[OUT_W-1:0];
    end else begin
      dev_sat = (q_ext > QE_W'(DEV_MIN_NEG)) ? DEV_MIN_NEG
                                              : (~q_ext[OUT_W-1:0] + OUT_W'(1));
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    seed_nxt      = seed_r;
    pa_nxt        = pa_r;
    ps_nxt        = ps_r;
    x_nxt         = x_r;
    idx_nxt       = idx_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    start_nxt     = 1'b0;
    avg_nxt       = avg_r;
    neg_nxt       = neg_r;
    dev_nxt       = dev_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_avg_nxt   = out_avg_r;
    out_dev_nxt   = out_dev_r;
    out_zero_nxt  = out_zero_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt   = x_in;
          idx_nxt = idx_in;
          if (idx_in == '0) begin
            seed_nxt  = '0;
            pa_nxt    = '0;
            ps_nxt    = x_in;
            count_nxt = COUNT_W'(1);
          end else if (idx_in < {1'b0, n}) begin
            seed_nxt  = seed_add;
            ps_nxt    = x_in;
            count_nxt = idx_in + COUNT_W'(1);
          end else if (idx_in == {1'b0, n}) begin
            // Seed: the first average is the plain mean of the summed samples.
            seed_nxt  = seed_add;
            num_nxt   = NUM_W'(seed_add) << FB;
            den_nxt   = DEN_W'(n);
            start_nxt = 1'b1;
            state_nxt = S_DIV1;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        num_nxt   = NUM_W'(prod) + NUM_W'(x_shift);
        den_nxt   = DEN_W'(n);
        start_nxt = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (div_stat.done) begin
          avg_nxt   = div_q[AVG_W-1:0];
          state_nxt = S_DEV;
        end
      end
      S_DEV: begin
        if (avg_r == '0) begin
          dev_nxt   = '0;
          zero_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          neg_nxt   = p_below;
          zero_nxt  = 1'b0;
          num_nxt   = dev_num;
          den_nxt   = DEN_W'(avg_r);
          start_nxt = 1'b1;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_stat.done) begin
          dev_nxt   = dev_sat;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_wide[OUT_W-1:0];
          out_dev_nxt   = dev_r;
          out_zero_nxt  = zero_r;
          pa_nxt        = avg_r;
          ps_nxt        = x_r;
          count_nxt     = (idx_r == COUNT_MAX) ? COUNT_MAX : idx_r + COUNT_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WIN_RESET;
      count_r     <= '0;
      seed_r      <= '0;
      pa_r        <= '0;
      ps_r        <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        wl_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      seed_r      <= seed_nxt;
      pa_r        <= pa_nxt;
      ps_r        <= ps_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    idx_r      <= idx_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    avg_r      <= avg_nxt;
    neg_r      <= neg_nxt;
    dev_r      <= dev_nxt;
    zero_r     <= zero_nxt;
    out_avg_r  <= out_avg_nxt;
    out_dev_r  <= out_dev_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_tdata  = {out_dev_r, out_avg_r};
  assign out_tuser  = out_zero_r;
  assign out_tvalid = out_valid_r;

  // No new word may enter while the divider is working on the current one.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_tready)
    else $error("input accepted while divider busy");

  // A divider completion only arrives in a state that waits for it.
  a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider done outside a divide state");

  // A zero average always goes out with zero deviation and zero average value.
  a_zero_avg_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero average word carries nonzero data");

endmodule

>>> rtl/core/rmad_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module rmad_div
  import rmad_pkg::*;
#(
  parameter int unsigned NUM_W = 71,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;

  // The quotient register doubles as the dividend shift register.
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[NUM_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule
